/* rtl/pkts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkts_pkg: shared types and constants of the priority-key task scheduler
// Task storage layout, queue entry, result record and back-end states.
// ----------------------------------------------------------------------------
package pkts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam int EXEC_W    = 12;
    localparam int KEY_W     = 16;
    localparam int TICK_W    = 16;
    localparam int ID_W      = 5;

    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int Q_CW      = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [KEY_W-1:0]  period;
        logic [KEY_W-1:0]  deadline;
        logic [EXEC_W-1:0] exec_time;
    } task_entry_t;

    // One request as classified by the front end
    typedef struct packed {
        task_entry_t task_data;
        logic        store;     // task fits in the set
        logic        last;      // closes the set
        logic        key_mode;  // key selection sampled with the request
    } q_entry_t;

    typedef struct packed {
        logic              last_result;
        logic [TICK_W-1:0] turnaround_time;
        logic [TICK_W-1:0] waiting_time;
        logic [TICK_W-1:0] completion_time;
        logic [ID_W-1:0]   task_id;
    } result_t;

    typedef enum logic [2:0] {
        BK_LOAD,
        BK_FETCH,
        BK_LATCH,
        BK_SCAN,
        BK_EMIT
    } back_state_t;

endpackage

/* rtl/pkts_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkts_front: request intake and classification
// Holds the key-mode register, counts tasks of the open set and tags each
// request with store/last flags before it enters the queue.
// ----------------------------------------------------------------------------
module pkts_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  pkts_pkg::task_entry_t in_task,
    input  logic               in_last,
    output logic               q_valid,
    input  logic               q_ready,
    output pkts_pkg::q_entry_t q_data
);

    logic                       key_mode_reg;
    logic [pkts_pkg::CNT_W-1:0] fcount_reg;
    logic [pkts_pkg::CNT_W-1:0] fcount_next;
    logic                       store;
    logic                       accept;

    assign in_ready = q_ready;
    assign q_valid  = in_valid;
    assign accept   = in_valid && q_ready;
    assign store    = fcount_reg < pkts_pkg::CNT_W'(pkts_pkg::MAX_TASKS);

    assign q_data.task_data = in_task;
    assign q_data.store     = store;
    assign q_data.last      = in_last;
    assign q_data.key_mode  = key_mode_reg;

    // Drop count back to zero when the set closes
    always_comb
    begin
        fcount_next = fcount_reg;
        if (accept)
        begin
            if (in_last)
                fcount_next = '0;
            else if (store)
                fcount_next = fcount_reg + pkts_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_mode_reg <= 1'b0;
            fcount_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                key_mode_reg <= cfg_wr_data;
            fcount_reg <= fcount_next;
        end
    end

endmodule

/* rtl/pkts_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkts_queue: short request queue between front and back end
// Small register FIFO; lets intake continue while the back end schedules.
// ----------------------------------------------------------------------------
module pkts_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  pkts_pkg::q_entry_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output pkts_pkg::q_entry_t pop_data
);

    pkts_pkg::q_entry_t        buf_reg [pkts_pkg::Q_DEPTH];
    logic [pkts_pkg::Q_AW-1:0] wr_ptr_reg;
    logic [pkts_pkg::Q_AW-1:0] rd_ptr_reg;
    logic [pkts_pkg::Q_CW-1:0] cnt_reg;
    logic [pkts_pkg::Q_CW-1:0] cnt_next;
    logic                      push;
    logic                      pop;

    assign push_ready = cnt_reg != pkts_pkg::Q_CW'(pkts_pkg::Q_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = buf_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + pkts_pkg::Q_CW'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - pkts_pkg::Q_CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + pkts_pkg::Q_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + pkts_pkg::Q_AW'(1);
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* rtl/pkts_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkts_back: task store and completion-time evaluator
// Loads queued tasks into a memory; when a set closes, computes for each
// task its exec time plus those of the tasks ranked ahead; 0 if its own is 0.
// ----------------------------------------------------------------------------
module pkts_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  pkts_pkg::q_entry_t q_data,
    output logic               out_valid,
    input  logic               out_ready,
    output pkts_pkg::result_t  out_data
);

    pkts_pkg::task_entry_t       mem [pkts_pkg::MAX_TASKS];
    pkts_pkg::task_entry_t       rd_data_reg;
    logic [pkts_pkg::IDX_W-1:0]  rd_addr;
    logic                        mem_we;

    pkts_pkg::back_state_t       state_reg, state_next;
    logic [pkts_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [pkts_pkg::IDX_W-1:0]  i_reg, i_next;
    logic [pkts_pkg::IDX_W-1:0]  jd_reg, jd_next;
    logic                        mode_reg, mode_next;
    logic [pkts_pkg::EXEC_W-1:0] cur_exec_reg, cur_exec_next;
    logic [pkts_pkg::KEY_W-1:0]  cur_key_reg, cur_key_next;
    logic [pkts_pkg::TICK_W-1:0] acc_reg, acc_next;
    logic                        out_valid_reg, out_valid_next;
    pkts_pkg::result_t           out_reg, out_next;

    logic [pkts_pkg::KEY_W-1:0]  rd_key;
    logic                        ahead;
    logic                        scan_end;
    logic                        emit_go;
    logic                        is_last;
    logic [pkts_pkg::CNT_W-1:0]  id_full;
    logic [pkts_pkg::TICK_W-1:0] comp;

    assign q_ready   = state_reg == pkts_pkg::BK_LOAD;
    assign mem_we    = q_valid && q_ready && q_data.store;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign rd_key   = mode_reg ? rd_data_reg.period : rd_data_reg.deadline;
    assign ahead    = (rd_key < cur_key_reg)
                   || ((rd_key == cur_key_reg) && (jd_reg < i_reg));
    assign scan_end = (pkts_pkg::CNT_W'(jd_reg) + pkts_pkg::CNT_W'(1)) == count_reg;
    assign emit_go  = !out_valid_reg || out_ready;
    assign id_full  = pkts_pkg::CNT_W'(i_reg) + pkts_pkg::CNT_W'(1);
    assign is_last  = id_full == count_reg;
    assign comp     = (cur_exec_reg == '0) ? '0 : acc_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[count_reg[pkts_pkg::IDX_W-1:0]] <= q_data.task_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        jd_next        = jd_reg;
        mode_next      = mode_reg;
        cur_exec_next  = cur_exec_reg;
        cur_key_next   = cur_key_reg;
        acc_next       = acc_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rd_addr        = i_reg;

        unique case (state_reg)
            pkts_pkg::BK_LOAD:
            begin
                if (q_valid)
                begin
                    if (q_data.store)
                        count_next = count_reg + pkts_pkg::CNT_W'(1);
                    if (q_data.last)
                    begin
                        mode_next  = q_data.key_mode;
                        i_next     = '0;
                        state_next = pkts_pkg::BK_FETCH;
                    end
                end
            end
            pkts_pkg::BK_FETCH:
            begin
                rd_addr    = i_reg;
                state_next = pkts_pkg::BK_LATCH;
            end
            pkts_pkg::BK_LATCH:
            begin
                // Own execution time seeds the sum; scan starts at entry zero
                cur_exec_next = rd_data_reg.exec_time;
                cur_key_next  = rd_key;
                acc_next      = pkts_pkg::TICK_W'(rd_data_reg.exec_time);
                rd_addr       = '0;
                jd_next       = '0;
                state_next    = pkts_pkg::BK_SCAN;
            end
            pkts_pkg::BK_SCAN:
            begin
                rd_addr = jd_reg + pkts_pkg::IDX_W'(1);
                if (ahead)
                    acc_next = acc_reg + pkts_pkg::TICK_W'(rd_data_reg.exec_time);
                jd_next = jd_reg + pkts_pkg::IDX_W'(1);
                if (scan_end)
                    state_next = pkts_pkg::BK_EMIT;
            end
            pkts_pkg::BK_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next          = 1'b1;
                    out_next.task_id        = pkts_pkg::ID_W'(id_full);
                    out_next.completion_time = comp;
                    out_next.waiting_time   = comp - pkts_pkg::TICK_W'(cur_exec_reg);
                    out_next.turnaround_time = comp;
                    out_next.last_result    = is_last;
                    if (is_last)
                    begin
                        count_next = '0;
                        i_next     = '0;
                        state_next = pkts_pkg::BK_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + pkts_pkg::IDX_W'(1);
                        state_next = pkts_pkg::BK_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = pkts_pkg::BK_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_exec_reg <= cur_exec_next;
        cur_key_reg  <= cur_key_next;
        acc_reg      <= acc_next;
        out_reg      <= out_next;
        jd_reg       <= jd_next;
        mode_reg     <= mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pkts_pkg::BK_LOAD;
            count_reg     <= '0;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            i_reg         <= i_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pkts_pkg::CNT_W'(pkts_pkg::MAX_TASKS))
        else $error("task count above capacity");

    a_scan_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pkts_pkg::BK_SCAN) |-> (pkts_pkg::CNT_W'(jd_reg) < count_reg))
        else $error("scan index outside loaded set");

    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != pkts_pkg::BK_LOAD) |-> (count_reg != '0))
        else $error("schedule run with empty set");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pkts_pkg::BK_EMIT && emit_go && is_last)
        |=> (state_reg == pkts_pkg::BK_LOAD && count_reg == '0 && out_reg.last_result))
        else $error("set not cleared after final result");
`endif

endmodule

/* rtl/priority_key_task_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_key_task_scheduler: EDF / rate-monotonic completion-time engine
// Loads a task set and returns per-task completion, waiting and turnaround.
// ----------------------------------------------------------------------------
// Usage:
//   Send one request per task on the s_ stream; s_tlast closes the set.
//   Tasks past the capacity of the set are dropped; a dropped closing request
//   still triggers scheduling of the stored tasks.
//   cfg_wr_en / cfg_wr_data write key_mode (0: deadline key, 1: period key);
//   write it only while the block is idle. It is sampled with each request.
//   After the closing request the m_ stream returns one result per task in
//   load order, m_tlast on the result of the final task.
// Flow:
//   While loading, the back end accepts a queued request whenever one is
//   present. For each result it reads the task from memory (FETCH, LATCH),
//   then reads each task of the set in turn through the single task-memory
//   read port (SCAN), then loads the output register (EMIT). A four-entry
//   request queue takes up to four requests of the next set while results
//   compute; s_tready then drops until loading resumes.
// Reset: clears counts, the queue and key_mode; no memory clearing pass.
// Stall: a result waits in the output register while m_tready is low;
//   the next result is computed meanwhile and then held back.
// ----------------------------------------------------------------------------
module priority_key_task_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // exec_time[11:0], deadline[27:12], period[43:28]
    input  logic        s_tlast,   // last_task
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // task_id[4:0], completion_time[20:5],
                                   // waiting_time[36:21], turnaround_time[52:37]
    output logic        m_tlast    // last_result
);

    pkts_pkg::task_entry_t in_task;
    pkts_pkg::q_entry_t    fq_data;
    pkts_pkg::q_entry_t    qb_data;
    pkts_pkg::result_t     res;
    logic                  fq_valid;
    logic                  fq_ready;
    logic                  qb_valid;
    logic                  qb_ready;

    // Unpack the request; padding bits above the period field are ignored
    assign in_task.exec_time = s_tdata[11:0];
    assign in_task.deadline  = s_tdata[27:12];
    assign in_task.period    = s_tdata[43:28];

    pkts_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_task     (in_task),
        .in_last     (s_tlast),
        .q_valid     (fq_valid),
        .q_ready     (fq_ready),
        .q_data      (fq_data)
    );

    pkts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    pkts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_data    (qb_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    // Pack the result, first field lowest, zero-filled to whole bytes
    assign m_tdata = {3'b000, res.turnaround_time, res.waiting_time,
                      res.completion_time, res.task_id};
    assign m_tlast = res.last_result;

endmodule
